### rtl/ale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_pkg: shared types and codes of the list compaction engine
// sizes of the list store, action codes and the compare unit request
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int CAPACITY = 64;
    localparam int WORD_W   = 32;
    localparam int ACT_W    = 3;
    localparam int RIDX_W   = 6;
    localparam int OCNT_W   = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // width wide enough to compare the read index against the count
    localparam int RDC_W    = (RIDX_W > CNT_W) ? RIDX_W : CNT_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ACT_W-1:0]         t_act;

    // action codes
    localparam t_act ACT_APPEND = 3'd0;
    localparam t_act ACT_MIN    = 3'd1;
    localparam t_act ACT_REV    = 3'd2;
    localparam t_act ACT_REMEQ  = 3'd3;
    localparam t_act ACT_REMRNG = 3'd4;
    localparam t_act ACT_READ   = 3'd5;

    // compare unit operations
    typedef logic [1:0] t_cmp_op;
    localparam t_cmp_op CMP_LT  = 2'd0;   // a < b
    localparam t_cmp_op CMP_NE  = 2'd1;   // a != b
    localparam t_cmp_op CMP_OUT = 2'd2;   // a < b or a > c

    typedef struct packed {
        t_cmp_op op;
        t_word   a;
        t_word   b;
        t_word   c;
    } t_cmp_req;

endpackage
`default_nettype wire

### rtl/ale_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_req_if: action request channel
// valid/ready channel that carries one action word and its operands
// ----------------------------------------------------------------------------
interface ale_req_if;
    import ale_pkg::*;

    logic  valid;
    logic  ready;
    t_act  action;
    t_word new_word;
    t_word match_value;
    t_word range_low;
    t_word range_high;
    logic [RIDX_W-1:0] read_index;

    modport source (
        output valid, action, new_word, match_value, range_low, range_high, read_index,
        input  ready
    );
    modport sink (
        input  valid, action, new_word, match_value, range_low, range_high, read_index,
        output ready
    );
endinterface
`default_nettype wire

### rtl/ale_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_rsp_if: result channel
// valid/ready channel that carries the status, word and length of one result
// ----------------------------------------------------------------------------
interface ale_rsp_if;
    import ale_pkg::*;

    logic  valid;
    logic  ready;
    logic  ok;
    t_word word_out;
    logic [OCNT_W-1:0] count_out;

    modport source (
        output valid, ok, word_out, count_out,
        input  ready
    );
    modport sink (
        input  valid, ok, word_out, count_out,
        output ready
    );
endinterface
`default_nettype wire

### rtl/ale_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ale_cmp: shared signed compare unit
// one signed comparator pair used by the scans and the range check
// ----------------------------------------------------------------------------
module ale_cmp (
    input  ale_pkg::t_cmp_req i_req,
    output logic              o_hit
);
    import ale_pkg::*;

    always_comb begin
        unique case (i_req.op)
            CMP_LT:  o_hit = ($signed(i_req.a) < $signed(i_req.b));
            CMP_NE:  o_hit = (i_req.a != i_req.b);
            CMP_OUT: o_hit = ($signed(i_req.a) < $signed(i_req.b)) ||
                             ($signed(i_req.a) > $signed(i_req.c));
            default: o_hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/array_list_compaction_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_compaction_engine: list store with scan and compaction actions
// keeps an ordered list of signed words; each request word runs one action
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request word per action: append, take min, reverse,
//   remove equal, remove range or read at. o_rsp returns exactly one result
//   word per request: ok flag, word taken or read, and the new list length.
//   the list lives in a one-write, one-read store with a registered read port;
//   a small sequencer walks it and one shared signed compare unit decides
//   every min, match and range test.
// steps (request accept to result valid)
//   append, failing actions, and reverse or remove equal on a list too short
//   to walk: straight to the push step
//   read at: one read step, then the push step
//   take min, remove equal, remove range: a scan, one entry per cycle through
//   the read port with read and process overlapped, then the push step
//   reverse: a low and a high step per swapped pair, one closing pass, then
//   the push step
//   one action is in flight at a time; i_req.ready is high only while idle
// reset
//   synchronous, active low: list length cleared, no result pending; the store
//   contents are not cleared, only entries below the length are ever read
// stalls
//   the result sits in an output register; the next request is taken while it
//   waits, and a finished action waits in its push step until that register
//   frees up
// ----------------------------------------------------------------------------
module array_list_compaction_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ale_req_if.sink   i_req,
    ale_rsp_if.source o_rsp
);
    import ale_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_REV  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    // list store
    t_word r_mem [CAPACITY];
    t_word r_rdata;

    // control state
    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    logic       r_vld,   n_vld;      // read data valid for the scan step
    logic       r_ovalid, n_ovalid;

    // action operands latched at accept
    t_act  r_action, n_action;
    t_word r_match,  n_match;
    t_word r_lo,     n_lo;
    t_word r_hi,     n_hi;

    // scan and reverse bookkeeping
    t_cnt  r_rd_idx, n_rd_idx;       // next entry to read
    t_idx  r_cur,    n_cur;          // entry whose data is in r_rdata
    t_word r_best,   n_best;         // running min, or saved word in reverse
    t_idx  r_pos,    n_pos;
    t_cnt  r_keep,   n_keep;         // compaction write pointer
    t_idx  r_rlo,    n_rlo;
    t_idx  r_rhi,    n_rhi;
    logic  r_ph,     n_ph;
    logic  r_pend,   n_pend;         // previous pair still has writes due

    // result staging and output register
    logic  r_res_ok,   n_res_ok;
    t_word r_res_word, n_res_word;
    logic  r_ook,      n_ook;
    t_word r_oword,    n_oword;
    logic [OCNT_W-1:0] r_ocount, n_ocount;

    // store ports
    logic  w_we;
    t_idx  w_waddr;
    t_word w_wdata;
    logic  w_re;
    t_idx  w_raddr;

    // shared compare unit
    t_cmp_req w_cmp;
    logic     w_hit;

    logic               w_accept;
    logic               w_last;
    logic               w_take;
    t_word              w_nbest;
    t_idx               w_npos;
    t_cnt               w_nkeep;
    logic [RDC_W-1:0]   w_ridx_x;

    ale_cmp u_cmp (
        .i_req (w_cmp),
        .o_hit (w_hit)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign w_accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.ok        = r_ook;
    assign o_rsp.word_out  = r_oword;
    assign o_rsp.count_out = r_ocount;

    assign w_ridx_x = RDC_W'(i_req.read_index);
    assign w_last   = (r_cur == t_idx'(r_count - t_cnt'(1)));

    // compare operand selection: range check while idle, element test in scan
    always_comb begin
        w_cmp.op = CMP_LT;
        w_cmp.a  = i_req.range_low;
        w_cmp.b  = i_req.range_high;
        w_cmp.c  = r_hi;
        if (r_state == S_SCAN) begin
            w_cmp.a = r_rdata;
            case (r_action)
                ACT_MIN: begin
                    w_cmp.op = CMP_LT;
                    w_cmp.b  = r_best;
                end
                ACT_REMEQ: begin
                    w_cmp.op = CMP_NE;
                    w_cmp.b  = r_match;
                end
                default: begin
                    w_cmp.op = CMP_OUT;
                    w_cmp.b  = r_lo;
                end
            endcase
        end
    end

    // min tracking and compaction pointer for the current scan step
    assign w_take  = (r_cur == '0) || w_hit;
    assign w_nbest = w_take ? r_rdata : r_best;
    assign w_npos  = w_take ? r_cur : r_pos;
    assign w_nkeep = w_hit ? (r_keep + t_cnt'(1)) : r_keep;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_vld      = r_vld;
        n_action   = r_action;
        n_match    = r_match;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_rd_idx   = r_rd_idx;
        n_cur      = r_cur;
        n_best     = r_best;
        n_pos      = r_pos;
        n_keep     = r_keep;
        n_rlo      = r_rlo;
        n_rhi      = r_rhi;
        n_ph       = r_ph;
        n_pend     = r_pend;
        n_res_ok   = r_res_ok;
        n_res_word = r_res_word;
        n_ook      = r_ook;
        n_oword    = r_oword;
        n_ocount   = r_ocount;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = i_req.new_word;
        w_re       = 1'b0;
        w_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action   = i_req.action;
                    n_match    = i_req.match_value;
                    n_lo       = i_req.range_low;
                    n_hi       = i_req.range_high;
                    n_rd_idx   = '0;
                    n_vld      = 1'b0;
                    n_keep     = '0;
                    n_res_ok   = 1'b0;
                    n_res_word = '0;
                    n_state    = S_PUSH;
                    case (i_req.action)
                        ACT_APPEND: begin
                            if (r_count < t_cnt'(CAPACITY)) begin
                                w_we     = 1'b1;
                                w_waddr  = r_count[IDX_W-1:0];
                                w_wdata  = i_req.new_word;
                                n_count  = r_count + t_cnt'(1);
                                n_res_ok = 1'b1;
                            end
                        end
                        ACT_MIN: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_REV: begin
                            if (r_count < t_cnt'(2)) begin
                                n_res_ok = 1'b1;
                            end else begin
                                n_rlo   = '0;
                                n_rhi   = t_idx'(r_count - t_cnt'(1));
                                n_ph    = 1'b0;
                                n_pend  = 1'b0;
                                n_state = S_REV;
                            end
                        end
                        ACT_REMEQ: begin
                            if (r_count == '0) begin
                                n_res_ok = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_REMRNG: begin
                            // w_hit is low < high here
                            if (w_hit && (r_count != '0)) begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            if (w_ridx_x < RDC_W'(r_count)) begin
                                w_re    = 1'b1;
                                w_raddr = w_ridx_x[IDX_W-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_res_ok = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read while the previous data is tested
                if (r_rd_idx < r_count) begin
                    w_re     = 1'b1;
                    w_raddr  = r_rd_idx[IDX_W-1:0];
                    n_rd_idx = r_rd_idx + t_cnt'(1);
                    n_cur    = r_rd_idx[IDX_W-1:0];
                    n_vld    = 1'b1;
                end else begin
                    n_vld    = 1'b0;
                end
                if (r_vld) begin
                    if (r_action == ACT_MIN) begin
                        n_best = w_nbest;
                        n_pos  = w_npos;
                        if (w_last) begin
                            // last word moves into the freed slot
                            w_we       = 1'b1;
                            w_waddr    = w_npos;
                            w_wdata    = r_rdata;
                            n_count    = r_count - t_cnt'(1);
                            n_res_ok   = 1'b1;
                            n_res_word = w_nbest;
                            n_state    = S_PUSH;
                        end
                    end else begin
                        // keep this word: copy it down to the write pointer
                        if (w_hit) begin
                            w_we    = 1'b1;
                            w_waddr = r_keep[IDX_W-1:0];
                            w_wdata = r_rdata;
                        end
                        n_keep = w_nkeep;
                        if (w_last) begin
                            n_count  = w_nkeep;
                            n_res_ok = 1'b1;
                            n_state  = S_PUSH;
                        end
                    end
                end
            end

            S_REV: begin
                if (!r_ph) begin
                    // finish low side of previous pair, fetch low word
                    if (r_pend) begin
                        w_we    = 1'b1;
                        w_waddr = r_rlo - t_idx'(1);
                        w_wdata = r_rdata;
                    end
                    w_re    = 1'b1;
                    w_raddr = r_rlo;
                    n_ph    = 1'b1;
                end else begin
                    // finish high side of previous pair, save low, fetch high
                    if (r_pend) begin
                        w_we    = 1'b1;
                        w_waddr = r_rhi + t_idx'(1);
                        w_wdata = r_best;
                    end
                    n_best  = r_rdata;
                    w_re    = 1'b1;
                    w_raddr = r_rhi;
                    n_ph    = 1'b0;
                    if (r_rlo < r_rhi) begin
                        n_pend = 1'b1;
                        n_rlo  = r_rlo + t_idx'(1);
                        n_rhi  = r_rhi - t_idx'(1);
                    end else begin
                        n_pend   = 1'b0;
                        n_res_ok = 1'b1;
                        n_state  = S_PUSH;
                    end
                end
            end

            S_READ: begin
                n_res_ok   = 1'b1;
                n_res_word = r_rdata;
                n_state    = S_PUSH;
            end

            S_PUSH: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ook    = r_res_ok;
                    n_oword  = r_res_word;
                    n_ocount = OCNT_W'(r_count);
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // list store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_vld    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ph     <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_vld    <= n_vld;
            r_ovalid <= n_ovalid;
            r_ph     <= n_ph;
            r_pend   <= n_pend;
        end
    end

    // operand, bookkeeping and payload registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_match    <= n_match;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_rd_idx   <= n_rd_idx;
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_pos      <= n_pos;
        r_keep     <= n_keep;
        r_rlo      <= n_rlo;
        r_rhi      <= n_rhi;
        r_res_ok   <= n_res_ok;
        r_res_word <= n_res_word;
        r_ook      <= n_ook;
        r_oword    <= n_oword;
        r_ocount   <= n_ocount;
    end

    // list length never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("list length above capacity");

    // an append into a list with room grows it by exactly one
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.action == ACT_APPEND) && (r_count < t_cnt'(CAPACITY)))
        |=> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("append did not grow the list by one");

    // a scan never writes above the entry under test, so unread words survive
    a_scan_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_we) |-> (w_waddr <= r_cur))
        else $error("scan write ahead of the read pointer");

    // a new result only appears from the push step
    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_PUSH))
        else $error("result raised outside the push step");

endmodule
`default_nettype wire

### tb/array_list_compaction_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_compaction_engine_checker: result predictor and scoreboard
// watches the request and result channels, keeps its own copy of the list,
// works out the result of every accepted request and compares in order
// ----------------------------------------------------------------------------
module array_list_compaction_engine_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ale_req_if   i_req,
    ale_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending
);
    import ale_pkg::*;

    typedef struct packed {
        logic              ok;
        t_word             word;
        logic [OCNT_W-1:0] len;
    } t_list_outcome;

    t_word         shadow_list [CAPACITY];
    int            shadow_len;
    t_list_outcome list_outcome_q [$];

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        shadow_len = 0;
    end

    // one action on the shadow list, returns the result word it must produce
    function automatic t_list_outcome run_list_action(
        input t_act              act,
        input t_word             nw,
        input t_word             mv,
        input t_word             lo,
        input t_word             hi,
        input logic [RIDX_W-1:0] ridx
    );
        t_list_outcome res;
        int            keep;
        int            pos;
        t_word         best;
        t_word         tmp;
        res = '0;
        case (act)
            ACT_APPEND: begin
                if (shadow_len < CAPACITY) begin
                    shadow_list[shadow_len] = nw;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            ACT_MIN: begin
                if (shadow_len > 0) begin
                    pos  = 0;
                    best = shadow_list[0];
                    // strict less-than keeps the first of equal minima
                    for (int i = 1; i < shadow_len; i++) begin
                        if (shadow_list[i] < best) begin
                            best = shadow_list[i];
                            pos  = i;
                        end
                    end
                    shadow_list[pos] = shadow_list[shadow_len-1];
                    shadow_len--;
                    res.ok   = 1'b1;
                    res.word = best;
                end
            end
            ACT_REV: begin
                for (int i = 0; i < shadow_len / 2; i++) begin
                    tmp                           = shadow_list[i];
                    shadow_list[i]                = shadow_list[shadow_len-1-i];
                    shadow_list[shadow_len-1-i]   = tmp;
                end
                res.ok = 1'b1;
            end
            ACT_REMEQ: begin
                keep = 0;
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow_list[i] != mv) begin
                        shadow_list[keep] = shadow_list[i];
                        keep++;
                    end
                end
                shadow_len = keep;
                res.ok     = 1'b1;
            end
            ACT_REMRNG: begin
                if (lo < hi && shadow_len > 0) begin
                    keep = 0;
                    for (int i = 0; i < shadow_len; i++) begin
                        if (shadow_list[i] < lo || shadow_list[i] > hi) begin
                            shadow_list[keep] = shadow_list[i];
                            keep++;
                        end
                    end
                    shadow_len = keep;
                    res.ok     = 1'b1;
                end
            end
            ACT_READ: begin
                if (int'(ridx) < shadow_len) begin
                    res.ok   = 1'b1;
                    res.word = shadow_list[ridx];
                end
            end
            default: ;
        endcase
        res.len = OCNT_W'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(
        input string         what,
        input t_list_outcome exp_res,
        input t_list_outcome got_res
    );
        o_errors++;
        if (o_errors <= 10)
            $display("%0t: %s: ok %0b/%0b word %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, what, exp_res.ok, got_res.ok, exp_res.word, got_res.word,
                     exp_res.len, got_res.len);
    endtask

    always @(posedge i_clk) begin
        t_list_outcome got_res;
        t_list_outcome exp_res;
        if (!i_rst_n) begin
            shadow_len = 0;
            list_outcome_q.delete();
        end else begin
            // result first: it always belongs to an earlier request
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                got_res.ok   = i_rsp.ok;
                got_res.word = i_rsp.word_out;
                got_res.len  = i_rsp.count_out;
                if (list_outcome_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got_res);
                end else begin
                    exp_res = list_outcome_q.pop_front();
                    if (got_res.ok !== exp_res.ok || got_res.word !== exp_res.word ||
                        got_res.len !== exp_res.len)
                        report_mismatch("result mismatch", exp_res, got_res);
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                list_outcome_q.push_back(run_list_action(i_req.action, i_req.new_word,
                    i_req.match_value, i_req.range_low, i_req.range_high,
                    i_req.read_index));
        end
        o_pending = list_outcome_q.size();
    end

endmodule

### tb/array_list_compaction_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_compaction_engine_tb: top of the list engine testbench
// directed corner actions, then random blocks of fill, drain and mixed traffic
// under three idle profiles; a checker beside the block scores every result
// ----------------------------------------------------------------------------
module array_list_compaction_engine_tb;
    import ale_pkg::*;

    // action codes the block must ignore
    localparam t_act ACT_SPARE6 = 3'd6;
    localparam t_act ACT_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 100;   // longest action is reverse
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 510;

    // traffic profile of one random block
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_NOISE
    } t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ale_req_if req_bus ();
    ale_rsp_if rsp_bus ();

    int errors;
    int pending;
    int cycle_cnt        = 0;
    int src_idle_pct     = 9;
    int rsp_idle_pct     = 63;
    bit hold_off_request = 1'b0;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    array_list_compaction_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    array_list_compaction_engine_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_bus),
        .i_rsp     (rsp_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_off_left;
        hold_off_left = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_off_left    = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("array_list_compaction_engine_tb: done, errors");
            $finish;
        end
    end

    // offer one request word; entered and left at a falling edge
    task automatic send_word(
        input t_act              act,
        input t_word             nw,
        input t_word             mv,
        input t_word             lo,
        input t_word             hi,
        input logic [RIDX_W-1:0] ridx
    );
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.action      <= act;
        req_bus.new_word    <= nw;
        req_bus.match_value <= mv;
        req_bus.range_low   <= lo;
        req_bus.range_high  <= hi;
        req_bus.read_index  <= ridx;
        do
            @(posedge i_clk);
        while (req_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // mostly a small pool so that ties, matches and range hits are common
    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_word'($urandom);
            3:       return 32'sh7fff_ffff;
            4:       return 32'sh8000_0000;
            default: return t_word'($signed($urandom_range(0, 12)) - 6);
        endcase
    endfunction

    function automatic t_act pick_action(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        // a sprinkle of the ignored codes in every profile
        if (r < 2)
            return ($urandom_range(0, 1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
        case (mix)
            MIX_FILL: begin
                if (r < 88)      return ACT_APPEND;
                else if (r < 92) return ACT_READ;
                else if (r < 95) return ACT_REV;
                else             return ACT_MIN;
            end
            MIX_DRAIN: begin
                if (r < 32)      return ACT_MIN;
                else if (r < 50) return ACT_REMEQ;
                else if (r < 70) return ACT_REMRNG;
                else if (r < 80) return ACT_READ;
                else if (r < 88) return ACT_REV;
                else             return ACT_APPEND;
            end
            MIX_BALANCED: begin
                if (r < 40)      return ACT_APPEND;
                else if (r < 55) return ACT_MIN;
                else if (r < 65) return ACT_REV;
                else if (r < 75) return ACT_REMEQ;
                else if (r < 85) return ACT_REMRNG;
                else             return ACT_READ;
            end
            default: return t_act'($urandom_range(0, 7));
        endcase
    endfunction

    // range bounds: mostly ordered, some equal, some inverted
    function automatic void pick_bounds(input t_mix mix, output t_word lo, output t_word hi);
        t_word a;
        t_word b;
        a = pick_word();
        b = pick_word();
        if (mix == MIX_NOISE) begin
            lo = t_word'($urandom);
            hi = t_word'($urandom);
        end else begin
            case ($urandom_range(0, 9))
                7: begin
                    lo = a;
                    hi = a;
                end
                8: begin
                    lo = (a > b) ? a : b;
                    hi = (a > b) ? b : a;
                end
                9: begin
                    lo = t_word'($urandom);
                    hi = t_word'($urandom);
                end
                default: begin
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
            endcase
        end
    endfunction

    task automatic send_random(input t_mix mix);
        t_act  act;
        t_word lo;
        t_word hi;
        logic [RIDX_W-1:0] ridx;
        act = pick_action(mix);
        pick_bounds(mix, lo, hi);
        // low indexes hit live entries more often
        ridx = ($urandom_range(0, 1) != 0) ? RIDX_W'($urandom_range(0, 15))
                                           : RIDX_W'($urandom_range(0, 63));
        send_word(act, pick_word(), pick_word(), lo, hi, ridx);
    endtask

    // one idle profile worth of random blocks
    task automatic run_phase(input int phase);
        int   sent;
        int   block_len;
        int   block_idx;
        int   r;
        t_mix mix;
        sent      = 0;
        block_idx = 0;
        while (sent < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 9);
            if (r < 3)      mix = MIX_FILL;
            else if (r < 6) mix = MIX_DRAIN;
            else if (r < 9) mix = MIX_BALANCED;
            else            mix = MIX_NOISE;
            // fill blocks run long enough to reach a full list
            block_len = (mix == MIX_FILL) ? $urandom_range(60, 90) : $urandom_range(20, 60);
            // last block of the phase stops at the phase size
            if (block_len > ITEMS_PER_PHASE - sent)
                block_len = ITEMS_PER_PHASE - sent;
            // long result hold-off while requests keep coming, the engine backs up
            if (phase == 0 && block_idx == 3)
                hold_off_request = 1'b1;
            repeat (block_len) send_random(mix);
            sent += block_len;
            // source pause until every outstanding result is back
            if (phase == 1 && block_idx == 3) begin
                req_bus.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            block_idx++;
        end
    endtask

    initial begin
        req_bus.valid       = 1'b0;
        req_bus.action      = ACT_APPEND;
        req_bus.new_word    = '0;
        req_bus.match_value = '0;
        req_bus.range_low   = '0;
        req_bus.range_high  = '0;
        req_bus.read_index  = '0;

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: take min and remove range fail, reverse and remove equal pass
        send_word(ACT_MIN,    0, 0, 0, 0, 0);
        send_word(ACT_REV,    0, 0, 0, 0, 0);
        send_word(ACT_REMEQ,  0, 0, 0, 0, 0);
        send_word(ACT_REMRNG, 0, 0, -10, 10, 0);
        send_word(ACT_READ,   0, 0, 0, 0, 0);
        // ignored codes with all-ones operands
        send_word(ACT_SPARE6, '1, '1, '1, '1, '1);
        send_word(ACT_SPARE7, '1, '1, '1, '1, '1);
        // extremes and a tied minimum
        send_word(ACT_APPEND, 32'sh7fff_ffff, 0, 0, 0, 0);
        send_word(ACT_APPEND, 32'sh8000_0000, 0, 0, 0, 0);
        send_word(ACT_APPEND, 0, 0, 0, 0, 0);
        send_word(ACT_APPEND, -1, 0, 0, 0, 0);
        send_word(ACT_APPEND, 32'sh8000_0000, 0, 0, 0, 0);
        send_word(ACT_APPEND, 5, 0, 0, 0, 0);
        send_word(ACT_READ,   0, 0, 0, 0, 1);
        send_word(ACT_READ,   0, 0, 0, 0, 63);
        send_word(ACT_MIN,    0, 0, 0, 0, 0);
        send_word(ACT_REV,    0, 0, 0, 0, 0);
        send_word(ACT_READ,   0, 0, 0, 0, 0);
        // equal and inverted bounds fail
        send_word(ACT_REMRNG, 0, 0, 3, 3, 0);
        send_word(ACT_REMRNG, 0, 0, 7, -7, 0);
        send_word(ACT_REMRNG, 0, 0, -1, 1, 0);
        send_word(ACT_REMEQ,  0, 32'sh7fff_ffff, 0, 0, 0);
        // full span empties the list
        send_word(ACT_REMRNG, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        send_word(ACT_MIN,    0, 0, 0, 0, 0);

        // idle profiles: source light / sink heavy, swapped, then none
        run_phase(0);
        src_idle_pct = 63;
        rsp_idle_pct = 9;
        run_phase(1);
        src_idle_pct = 0;
        rsp_idle_pct = 0;
        run_phase(2);

        req_bus.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("array_list_compaction_engine_tb: done, clean");
        else
            $display("array_list_compaction_engine_tb: done, errors");
        $finish;
    end

endmodule
